// File: sv/kcd_pkg.sv
// ----------------------------------------------------------------------------
// kcd_pkg: shared types and constants for the key click detector
// Key phase and event codes, register indexes and threshold defaults.
// ----------------------------------------------------------------------------
package kcd_pkg;

  // Counter width default and threshold register width
  localparam int COUNT_WIDTH_DEF = 16;
  localparam int THR_W           = 16;
  localparam int CFG_IDX_W       = 2;

  // Threshold reset values
  localparam logic [THR_W-1:0] DEAD_TICKS_RST   = 16'd5;
  localparam logic [THR_W-1:0] DOUBLE_TICKS_RST = 16'd30;
  localparam logic [THR_W-1:0] HOLD_TICKS_RST   = 16'd100;

  // Register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_DEAD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD   = 2'd2;

  // Key phase
  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_CLICK   = 3'd1,
    PH_DOUBLE  = 3'd2,
    PH_LONG    = 3'd3,
    PH_PENDING = 3'd4
  } phase_t;

  // Reported event
  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_CLICK  = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_LONG   = 2'd3
  } event_t;

  // Time thresholds handed to the core
  typedef struct packed {
    logic [THR_W-1:0] dead_ticks;
    logic [THR_W-1:0] double_ticks;
    logic [THR_W-1:0] hold_ticks;
  } thr_cfg_t;

endpackage

// File: sv/key_click_double_long_detector.sv
// ----------------------------------------------------------------------------
// key_click_double_long_detector: click / double click / long press detector
// Input register, detector core and output register around one tick of work.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one word per key sample tick, in_key_pressed = 1 when pressed.
//   out_*  : one word per input word, out_event_res = none, click, double
//            click or long press.
//   cfg_*  : threshold writes (0 dead_ticks, 1 double_ticks, 2 hold_ticks);
//            other indexes are dropped. Write only while the block is idle.
// Timing:
//   An accepted word sits in the input register and goes through the core
//   logic into the output register once the output slot is free, which
//   raises out_valid. One word is accepted every cycle while out_ready
//   does not stall the output; the single state update per tick is the
//   only loop and it closes through the core state registers.
// Reset:
//   rst_n (synchronous, low) empties both registers, clears counters and
//   phase, and loads the default thresholds 5, 30 and 100.
// Stall:
//   While out_ready is low the output word holds, the input register fills,
//   and in_ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module key_click_double_long_detector #(
  parameter int COUNT_WIDTH = kcd_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_key_pressed,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_event_res,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [kcd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kcd_pkg::THR_W-1:0]       cfg_data
);

  logic              in_valid_r;
  logic              key_r;
  logic              out_valid_r;
  kcd_pkg::event_t   event_r;
  kcd_pkg::event_t   event_nxt;
  kcd_pkg::thr_cfg_t thr_r;
  logic              advance;

  // Core step when a tick is held and the output slot is free
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_event_res = event_r;

  // Threshold registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r.dead_ticks   <= kcd_pkg::DEAD_TICKS_RST;
      thr_r.double_ticks <= kcd_pkg::DOUBLE_TICKS_RST;
      thr_r.hold_ticks   <= kcd_pkg::HOLD_TICKS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        kcd_pkg::REG_DEAD:   thr_r.dead_ticks   <= cfg_data;
        kcd_pkg::REG_DOUBLE: thr_r.double_ticks <= cfg_data;
        kcd_pkg::REG_HOLD:   thr_r.hold_ticks   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      key_r <= in_key_pressed;
    end
  end

  kcd_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (advance),
    .key_pressed (key_r),
    .thr         (thr_r),
    .event_nxt   (event_nxt)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      event_r <= event_nxt;
    end
  end

endmodule

// File: sv/kcd_core.sv
// ----------------------------------------------------------------------------
// kcd_core: press/gap counters and key phase
// Holds the detector state, advances it by one tick when step is high and
// gives the event that tick causes.
// ----------------------------------------------------------------------------
module kcd_core #(
  parameter int COUNT_WIDTH = kcd_pkg::COUNT_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic               key_pressed,
  input  kcd_pkg::thr_cfg_t  thr,
  output kcd_pkg::event_t    event_nxt
);

  // Compare width covers both counters and thresholds
  localparam int CMP_W = (COUNT_WIDTH > kcd_pkg::THR_W) ? COUNT_WIDTH : kcd_pkg::THR_W;

  logic [COUNT_WIDTH-1:0] press_r, press_nxt;
  logic [COUNT_WIDTH-1:0] gap_r, gap_nxt;
  kcd_pkg::phase_t        phase_r, phase_nxt;

  logic [COUNT_WIDTH-1:0] press_inc, gap_inc, press_eff;
  logic [CMP_W-1:0]       dead_x, dbl_x, hold_x;
  logic                   hold_hit, done_phase, enter_pend, in_pend;
  logic                   gap_timeout, late_click;

  // Saturating increments
  assign press_inc = (press_r == {COUNT_WIDTH{1'b1}}) ? press_r : press_r + 1'b1;
  assign gap_inc   = (gap_r == {COUNT_WIDTH{1'b1}}) ? gap_r : gap_r + 1'b1;

  assign dead_x = CMP_W'(thr.dead_ticks);
  assign dbl_x  = CMP_W'(thr.double_ticks);
  assign hold_x = CMP_W'(thr.hold_ticks);

  // Decision flags for this tick
  always_comb begin
    hold_hit   = (CMP_W'(press_inc) >= hold_x) && (phase_r != kcd_pkg::PH_LONG);
    done_phase = (phase_r == kcd_pkg::PH_LONG) || (phase_r == kcd_pkg::PH_DOUBLE) ||
                 (phase_r == kcd_pkg::PH_CLICK);
    enter_pend = (CMP_W'(press_r) >= dead_x) && (CMP_W'(press_r) < dbl_x) &&
                 (phase_r != kcd_pkg::PH_PENDING);
    in_pend    = enter_pend || (phase_r == kcd_pkg::PH_PENDING);
    press_eff  = enter_pend ? '0 : press_r;
    // gap window elapsed while waiting for a second press
    gap_timeout = in_pend && (CMP_W'(gap_inc) >= dbl_x);
    late_click  = !gap_timeout && (CMP_W'(press_eff) >= dead_x) &&
                  (CMP_W'(press_eff) < hold_x);
  end

  // Next state
  always_comb begin
    press_nxt = press_r;
    gap_nxt   = gap_r;
    phase_nxt = phase_r;
    if (key_pressed) begin
      if (hold_hit) begin
        phase_nxt = kcd_pkg::PH_LONG;
        press_nxt = '0;
      end else if (phase_r == kcd_pkg::PH_PENDING) begin
        phase_nxt = kcd_pkg::PH_DOUBLE;
        gap_nxt   = '0;
        press_nxt = '0;
      end else begin
        press_nxt = press_inc;
      end
    end else if (done_phase) begin
      // first release after an event
      phase_nxt = kcd_pkg::PH_IDLE;
      press_nxt = '0;
      gap_nxt   = '0;
    end else begin
      press_nxt = press_eff;
      if (in_pend) begin
        phase_nxt = kcd_pkg::PH_PENDING;
        gap_nxt   = gap_inc;
      end
      if (gap_timeout) begin
        phase_nxt = kcd_pkg::PH_CLICK;
        gap_nxt   = '0;
        press_nxt = '0;
      end else if (late_click) begin
        phase_nxt = kcd_pkg::PH_CLICK;
        press_nxt = '0;
      end
    end
  end

  // Event output
  always_comb begin
    event_nxt = kcd_pkg::EV_NONE;
    if (key_pressed) begin
      if (hold_hit) begin
        event_nxt = kcd_pkg::EV_LONG;
      end else if (phase_r == kcd_pkg::PH_PENDING) begin
        event_nxt = kcd_pkg::EV_DOUBLE;
      end
    end else if (!done_phase && (gap_timeout || late_click)) begin
      event_nxt = kcd_pkg::EV_CLICK;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_r <= '0;
      gap_r   <= '0;
      phase_r <= kcd_pkg::PH_IDLE;
    end else if (step) begin
      press_r <= press_nxt;
      gap_r   <= gap_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

// File: dv/key_click_double_long_detector_tb.sv
// ----------------------------------------------------------------------------
// key_click_double_long_detector_tb: testbench for the key event detector
// Sends key samples one word per tick and predicts click, double click and
// long press events in step with the block. Every result word is checked
// in order against the prediction. The run covers the default thresholds,
// directed event sequences, a long held press, a long output stall and
// random press/release sequences under several threshold settings.
// ----------------------------------------------------------------------------
module key_click_double_long_detector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CNT_W = kcd_pkg::COUNT_WIDTH_DEF;
  // Index with no register behind it; writes to it are dropped
  localparam logic [kcd_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int DRAIN_LIMIT = 20000;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic                          in_key_pressed = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [1:0]                    out_event_res;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [kcd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [kcd_pkg::THR_W-1:0]     cfg_data = '0;

  key_click_double_long_detector u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_key_pressed(in_key_pressed),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_event_res (out_event_res),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #10 clk = ~clk;

  // Predicted detector state and thresholds
  kcd_pkg::thr_cfg_t thr = '{dead_ticks: kcd_pkg::DEAD_TICKS_RST,
                             double_ticks: kcd_pkg::DOUBLE_TICKS_RST,
                             hold_ticks: kcd_pkg::HOLD_TICKS_RST};
  logic [CNT_W-1:0]  press_cnt = '0;
  logic [CNT_W-1:0]  gap_cnt = '0;
  kcd_pkg::phase_t   key_ph = kcd_pkg::PH_IDLE;

  kcd_pkg::event_t expected_events[$];
  int unsigned     fail_count = 0;
  int unsigned     words_sent = 0;

  // Sender pacing
  int unsigned burst_left = 0;
  bit          tx_steady = 1'b0;
  // Long output stall request, picked up by the receiver
  int unsigned hold_off_req = 0;

  // One tick of the detector: updates the predicted state, returns the event
  function automatic kcd_pkg::event_t predict_key_event(bit down);
    kcd_pkg::event_t ev;
    ev = kcd_pkg::EV_NONE;
    if (down) begin
      if (press_cnt != '1) press_cnt = press_cnt + 1'b1;
      if (press_cnt >= thr.hold_ticks && key_ph != kcd_pkg::PH_LONG) begin
        key_ph = kcd_pkg::PH_LONG;
        press_cnt = '0;
        ev = kcd_pkg::EV_LONG;
      end else if (key_ph == kcd_pkg::PH_PENDING) begin
        key_ph = kcd_pkg::PH_DOUBLE;
        gap_cnt = '0;
        press_cnt = '0;
        ev = kcd_pkg::EV_DOUBLE;
      end
    end else if (key_ph inside {kcd_pkg::PH_LONG, kcd_pkg::PH_DOUBLE,
                                kcd_pkg::PH_CLICK}) begin
      // first release after an event just clears
      press_cnt = '0;
      gap_cnt = '0;
      key_ph = kcd_pkg::PH_IDLE;
    end else begin
      if (press_cnt >= thr.dead_ticks && press_cnt < thr.double_ticks &&
          key_ph != kcd_pkg::PH_PENDING) begin
        key_ph = kcd_pkg::PH_PENDING;
        press_cnt = '0;
      end
      if (key_ph == kcd_pkg::PH_PENDING) begin
        if (gap_cnt != '1) gap_cnt = gap_cnt + 1'b1;
        if (gap_cnt >= thr.double_ticks) begin
          key_ph = kcd_pkg::PH_CLICK;
          gap_cnt = '0;
          press_cnt = '0;
          ev = kcd_pkg::EV_CLICK;
        end
      end
      if (ev == kcd_pkg::EV_NONE && press_cnt >= thr.dead_ticks &&
          press_cnt < thr.hold_ticks) begin
        key_ph = kcd_pkg::PH_CLICK;
        press_cnt = '0;
        ev = kcd_pkg::EV_CLICK;
      end
    end
    return ev;
  endfunction

  // Result check first, then prediction for the word accepted at this edge
  always @(posedge clk) begin
    kcd_pkg::event_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_events.size() == 0) begin
          $error("event_res: expected none waiting, actual %0d", out_event_res);
          fail_count++;
        end else begin
          want = expected_events.pop_front();
          if (out_event_res !== want) begin
            $error("event_res: expected %0d, actual %0d", want, out_event_res);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) expected_events.push_back(predict_key_event(in_key_pressed));
    end
  end

  // Receiver: stall pattern picked at random from three modes; long hold-off on request
  always @(negedge clk) begin
    static int unsigned rx_cyc = 0;
    static int unsigned rx_mode = 0;
    static int unsigned hold_left = 0;
    rx_cyc++;
    if (rx_cyc % 128 == 0) rx_mode = $urandom_range(0, 2);
    if (hold_off_req != 0) begin
      hold_left = hold_off_req;
      hold_off_req = 0;
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 2) != 0);
        default: out_ready <= ((rx_cyc % 7) > 1);
      endcase
    end
  end

  // Send one key sample word; gaps fall between random bursts unless tx_steady is set
  task automatic send_key(bit down);
    int unsigned gap;
    if (!tx_steady && burst_left == 0) begin
      gap = $urandom_range(1, 5);
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200) :
                                                 $urandom_range(1, 12);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_key_pressed <= down;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    if (burst_left != 0) burst_left--;
  endtask

  task automatic run_key(bit down, int unsigned n);
    repeat (n) send_key(down);
  endtask

  task automatic park_input();
    @(negedge clk) in_valid <= 1'b0;
  endtask

  // Wait until every predicted event has come back
  task automatic wait_events_drained();
    int unsigned n;
    n = 0;
    while (expected_events.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    if (expected_events.size() != 0) begin
      $error("event_res: %0d expected words never arrived", expected_events.size());
      fail_count++;
      expected_events.delete();
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic [kcd_pkg::CFG_IDX_W-1:0] idx,
                           logic [kcd_pkg::THR_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      kcd_pkg::REG_DEAD:   thr.dead_ticks = data;
      kcd_pkg::REG_DOUBLE: thr.double_ticks = data;
      kcd_pkg::REG_HOLD:   thr.hold_ticks = data;
      default: ;
    endcase
  endtask

  // Only called with the block idle
  task automatic set_thresholds(logic [kcd_pkg::THR_W-1:0] dead,
                                logic [kcd_pkg::THR_W-1:0] dbl,
                                logic [kcd_pkg::THR_W-1:0] hold);
    park_input();
    wait_events_drained();
    cfg_write(kcd_pkg::REG_DEAD, dead);
    cfg_write(REG_SPARE, kcd_pkg::THR_W'($urandom));
    cfg_write(kcd_pkg::REG_DOUBLE, dbl);
    cfg_write(kcd_pkg::REG_HOLD, hold);
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  // Default thresholds after reset: short press then second press
  task automatic test_default_double();
    run_key(1'b1, 5);
    run_key(1'b0, 1);
    run_key(1'b1, 1);
    run_key(1'b0, 1);
  endtask

  // Long, medium press, click by gap timeout, short presses adding up
  task automatic test_event_kinds();
    set_thresholds(16'd2, 16'd4, 16'd7);
    run_key(1'b1, 7);
    run_key(1'b0, 1);
    run_key(1'b1, 5);
    run_key(1'b0, 1);
    run_key(1'b1, 2);
    run_key(1'b0, 4);
    run_key(1'b1, 1);
    run_key(1'b0, 1);
    run_key(1'b1, 1);
    run_key(1'b0, 4);
  endtask

  // Zero dead time: empty press goes pending straight from idle
  task automatic test_zero_thresholds();
    set_thresholds(16'd0, 16'd3, 16'd9);
    run_key(1'b0, 3);
    set_thresholds(16'd0, 16'd0, 16'd0);
    run_key(1'b1, 2);
    run_key(1'b0, 2);
  endtask

  // Press held well past the long threshold, then one tick under it
  task automatic test_long_hold();
    set_thresholds(16'd3, 16'd0, 16'd40);
    run_key(1'b1, 90);
    run_key(1'b0, 3);
    run_key(1'b1, 39);
    run_key(1'b0, 2);
    run_key(1'b1, 3);
    run_key(1'b0, 2);
  endtask

  // Receiver stalls for a long stretch while the sender keeps offering
  task automatic test_output_backpressure();
    set_thresholds(16'd1, 16'd3, 16'd6);
    hold_off_req = 120;
    tx_steady = 1'b1;
    repeat (40) send_key(1'($urandom_range(0, 1)));
    tx_steady = 1'b0;
    park_input();
    wait_events_drained();
  endtask

  function automatic int unsigned span_len(int unsigned lo, int unsigned hi);
    if (lo > 48) lo = 48;
    if (hi < lo) hi = lo;
    if (hi > lo + 40) hi = lo + 40;
    return $urandom_range(hi, lo);
  endfunction

  // Mostly well-formed press/release sequences sized from the thresholds
  task automatic run_key_sequences(int unsigned n);
    int unsigned start;
    int unsigned dead;
    int unsigned dbl;
    int unsigned hold;
    start = words_sent;
    dead = 32'(thr.dead_ticks);
    dbl = 32'(thr.double_ticks);
    hold = 32'(thr.hold_ticks);
    while (words_sent - start < n) begin
      case ($urandom_range(0, 9))
        0, 1: repeat ($urandom_range(1, 8)) send_key(1'($urandom_range(0, 1)));
        2, 3: begin
          // taps that may fall under the dead time
          run_key(1'b1, span_len(1, dead));
          run_key(1'b0, span_len(1, 3));
        end
        4, 5: begin
          run_key(1'b1, span_len((dead == 0) ? 1 : dead, dbl));
          run_key(1'b0, span_len(1, dbl));
          run_key(1'b1, span_len(1, 4));
          run_key(1'b0, span_len(1, 3));
        end
        6: begin
          run_key(1'b1, span_len(hold, hold + 6));
          run_key(1'b0, span_len(1, 3));
        end
        7, 8: begin
          // click that waits out the double window
          run_key(1'b1, span_len((dead == 0) ? 1 : dead, dbl));
          run_key(1'b0, span_len(dbl, dbl + 3));
        end
        default: begin
          run_key(1'b1, span_len(dbl, hold));
          run_key(1'b0, span_len(1, 4));
        end
      endcase
    end
  endtask

  // Random sequences under several settings, extremes among them
  task automatic test_random_sequences();
    set_thresholds(kcd_pkg::DEAD_TICKS_RST, kcd_pkg::DOUBLE_TICKS_RST,
                   kcd_pkg::HOLD_TICKS_RST);
    run_key_sequences(115);
    set_thresholds(16'd2, 16'd6, 16'd15);
    run_key_sequences(115);
    set_thresholds(16'd0, 16'd5, 16'd12);
    run_key_sequences(115);
    set_thresholds(16'd4, 16'd4, 16'd9);
    run_key_sequences(115);
    set_thresholds(16'd1, 16'd12, 16'd6);
    run_key_sequences(115);
    set_thresholds(16'hFFFF, 16'hFFFF, 16'd10);
    run_key_sequences(115);
    set_thresholds(kcd_pkg::THR_W'($urandom_range(0, 5)),
                   kcd_pkg::THR_W'($urandom_range(0, 12)),
                   kcd_pkg::THR_W'($urandom_range(0, 25)));
    run_key_sequences(115);
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    test_default_double();
    test_event_kinds();
    test_zero_thresholds();
    test_long_hold();
    test_output_backpressure();
    test_random_sequences();
    park_input();
    wait_events_drained();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Run limit, far above the slowest correct run
  initial begin
    #100ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
